// ----- hw/rtl/mcic_pkg.sv -----
package mcic_pkg;

  localparam int STACK_DEPTH_DEF = 4096;
  localparam int POS_W = 20;
  localparam int SCOST_W = 32;
  localparam int CCOST_W = 48;
  localparam logic [CCOST_W-1:0] COST_MAX = {CCOST_W{1'b1}};

  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_COVER_START = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_COVER_END = 1'b1;

  typedef struct packed {
    logic [POS_W-1:0]   seg_start;
    logic [POS_W-1:0]   seg_end;
    logic [SCOST_W-1:0] seg_cost;
    logic               new_set;
  } in_beat_t;

  typedef struct packed {
    logic [CCOST_W-1:0] chain_cost;
    logic               chain_ok;
    logic [CCOST_W-1:0] best_total;
    logic               best_ok;
    logic               stack_full;
  } out_beat_t;

  // queued item plus front-end classification
  typedef struct packed {
    in_beat_t beat;
    logic     first;
    logic     covers_end;
  } job_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TOP,
    ST_SEARCH,
    ST_FOUND,
    ST_POP,
    ST_PUSH,
    ST_OUT
  } eng_state_t;

endpackage

// ----- hw/rtl/mcic_front.sv -----
module mcic_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  mcic_pkg::in_beat_t   in_data,
  input  logic                 cfg_we,
  input  logic [mcic_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [mcic_pkg::POS_W-1:0]     cfg_data,
  output logic                 job_valid,
  input  logic                 job_ready,
  output mcic_pkg::job_t       job
);

  logic [mcic_pkg::POS_W-1:0] cover_start;
  logic [mcic_pkg::POS_W-1:0] cover_end;
  mcic_pkg::job_t q [2];
  logic [1:0] cnt;
  logic wp, rp;
  logic push, pop;
  mcic_pkg::job_t enq;

  // hold config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cover_start <= '0;
      cover_end <= '0;
    end else if (cfg_we) begin
      if (cfg_idx == mcic_pkg::REG_COVER_START) cover_start <= cfg_data;
      if (cfg_idx == mcic_pkg::REG_COVER_END) cover_end <= cfg_data;
    end
  end

  // classify the incoming beat
  always_comb begin
    enq.beat = in_data;
    enq.first = in_data.seg_start <= cover_start;
    enq.covers_end = in_data.seg_end >= cover_end;
  end

  assign in_ready = cnt != 2'd2;
  assign push = in_valid && in_ready;
  assign job_valid = cnt != 2'd0;
  assign pop = job_valid && job_ready;
  assign job = q[rp];

  // two-entry queue to the back end
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      wp <= 1'b0;
      rp <= 1'b0;
    end else begin
      if (push) wp <= ~wp;
      if (pop) rp <= ~rp;
      cnt <= cnt + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) q[wp] <= enq;
  end

endmodule

// ----- hw/rtl/mcic_engine.sv -----
module mcic_engine #(
  parameter int STACK_DEPTH = mcic_pkg::STACK_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                job_valid,
  output logic                job_ready,
  input  mcic_pkg::job_t      job,
  output logic                out_valid,
  input  logic                out_ready,
  output mcic_pkg::out_beat_t out_data
);

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int EW = mcic_pkg::POS_W + mcic_pkg::CCOST_W + 1;
  localparam logic [CW-1:0] DEPTH_C = CW'(STACK_DEPTH);

  logic [EW-1:0] mem [STACK_DEPTH];
  logic [EW-1:0] rd;
  logic [AW-1:0] raddr;
  logic          we;
  logic [AW-1:0] waddr;
  logic [EW-1:0] wdata;

  mcic_pkg::eng_state_t st, st_next;
  mcic_pkg::job_t       cur;
  logic [CW-1:0] count, lo, hi;
  logic [mcic_pkg::CCOST_W-1:0] cost, best;
  logic ok, best_v, full;
  logic [mcic_pkg::CCOST_W-1:0] rd_cost;
  logic [mcic_pkg::POS_W-1:0]   rd_end;
  logic rd_ok, reach, top_ge;
  logic [CW-1:0] mid;
  logic [mcic_pkg::CCOST_W:0] sum;
  logic search_rd;  // rd holds mem[mid of previous cycle]
  logic [CW-1:0] pmid;

  assign rd_end = rd[EW-1 -: mcic_pkg::POS_W];
  assign rd_cost = rd[mcic_pkg::CCOST_W:1];
  assign rd_ok = rd[0];
  assign reach = ({1'b0, rd_end} + 21'd1) >= {1'b0, cur.beat.seg_start};
  assign mid = lo + ((hi - lo) >> 1);
  assign sum = {1'b0, rd_cost} + {17'd0, cur.beat.seg_cost};
  assign top_ge = !rd_ok || (ok && rd_cost >= cost);

  // stack memory with registered read
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rd <= mem[raddr];
  end

  // next state
  always_comb begin
    st_next = st;
    unique case (st)
      mcic_pkg::ST_IDLE:   if (job_valid) st_next = mcic_pkg::ST_TOP;
      mcic_pkg::ST_TOP: begin
        if (ok || count == '0) st_next = (count == '0) ? mcic_pkg::ST_PUSH
                                                       : mcic_pkg::ST_POP;
        else if (reach) st_next = mcic_pkg::ST_SEARCH;
        else st_next = mcic_pkg::ST_POP;
      end
      mcic_pkg::ST_SEARCH: if (lo >= hi) st_next = mcic_pkg::ST_FOUND;
      mcic_pkg::ST_FOUND:  st_next = (count == '0) ? mcic_pkg::ST_PUSH
                                                   : mcic_pkg::ST_POP;
      mcic_pkg::ST_POP: if (!top_ge || count == '0) st_next = mcic_pkg::ST_PUSH;
      mcic_pkg::ST_PUSH:   st_next = mcic_pkg::ST_OUT;
      mcic_pkg::ST_OUT:    if (out_ready) st_next = mcic_pkg::ST_IDLE;
      default:             st_next = mcic_pkg::ST_IDLE;
    endcase
  end

  // outputs and read address
  always_comb begin
    job_ready = st == mcic_pkg::ST_IDLE;
    out_valid = st == mcic_pkg::ST_OUT;
    we = st == mcic_pkg::ST_PUSH && count < DEPTH_C;
    waddr = count[AW-1:0];
    wdata = {cur.beat.seg_end, ok ? cost : '0, ok};
    raddr = '0;
    unique case (st)
      mcic_pkg::ST_IDLE, mcic_pkg::ST_TOP, mcic_pkg::ST_FOUND:
        raddr = AW'(count - 1'b1);
      mcic_pkg::ST_SEARCH: raddr = (lo >= hi) ? AW'(lo) : AW'(mid);
      mcic_pkg::ST_POP:    raddr = AW'(count - 2'd2);
      mcic_pkg::ST_PUSH, mcic_pkg::ST_OUT: raddr = '0;
      default:             raddr = '0;
    endcase
  end

  // datapath: search, pop, push, best tracking
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= mcic_pkg::ST_IDLE;
      count <= '0;
      best_v <= 1'b0;
      best <= '0;
      search_rd <= 1'b0;
    end else begin
      st <= st_next;
      unique case (st)
        mcic_pkg::ST_IDLE: if (job_valid) begin
          cur <= job;
          ok <= job.first;
          cost <= {16'd0, job.beat.seg_cost};
          full <= 1'b0;
          if (job.beat.new_set) begin
            count <= '0;
            best_v <= 1'b0;
            best <= '0;
          end
        end
        mcic_pkg::ST_TOP: begin
          lo <= '0;
          hi <= count;
          search_rd <= 1'b0;
        end
        mcic_pkg::ST_SEARCH: begin
          if (search_rd) begin
            if (reach) hi <= pmid;
            else lo <= pmid + 1'b1;
            search_rd <= 1'b0;
          end else if (lo < hi) begin
            pmid <= mid;
            search_rd <= 1'b1;
          end
        end
        mcic_pkg::ST_FOUND: if (rd_ok) begin
          ok <= 1'b1;
          cost <= sum[mcic_pkg::CCOST_W] ? mcic_pkg::COST_MAX
                                         : sum[mcic_pkg::CCOST_W-1:0];
        end
        mcic_pkg::ST_POP: if (top_ge && count != '0) count <= count - 1'b1;
        mcic_pkg::ST_PUSH: begin
          if (count < DEPTH_C) count <= count + 1'b1;
          else full <= 1'b1;
          if (ok && cur.covers_end && (!best_v || cost < best)) begin
            best <= cost;
            best_v <= 1'b1;
          end
        end
        mcic_pkg::ST_OUT: ;
        default: ;
      endcase
    end
  end

  assign out_data = '{chain_cost: ok ? cost : '0, chain_ok: ok,
                      best_total: best_v ? best : '0, best_ok: best_v,
                      stack_full: full};

endmodule

// ----- hw/rtl/min_cost_interval_cover.sv -----
// Minimum-cost interval cover engine.
// in channel (in_valid/in_ready/in_data): one interval beat, sorted by end.
// out channel (out_valid/out_ready/out_data): one result beat per input.
// cfg port (cfg_we/cfg_idx/cfg_data): index 0 cover_start, 1 cover_end.
// Front end classifies and queues beats (two deep); the back end walks a
// stack held in one memory with a write port and a registered read port.
// A beat is registered in the queue before the back end takes it. Per item
// the back end reads the stack top, then, if the item has no chain yet and
// the top reaches its start, runs a binary search (steps: about log2 of the
// stack count) for a predecessor, pops dominated entries, pushes the item
// and holds the result; it takes the next beat only once that is accepted.
// Reset (rst, synchronous) empties the stack and queue, clears the best
// and both registers; no clearing pass is needed.
// A stalled receiver holds the result; the front queue keeps taking up to
// two more beats meanwhile.
module min_cost_interval_cover #(
  parameter int STACK_DEPTH = mcic_pkg::STACK_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  mcic_pkg::in_beat_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output mcic_pkg::out_beat_t out_data,
  input  logic                cfg_we,
  input  logic [mcic_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [mcic_pkg::POS_W-1:0]     cfg_data
);

  logic job_valid, job_ready;
  mcic_pkg::job_t job;

  mcic_front u_front (
    .clk, .rst, .in_valid, .in_ready, .in_data,
    .cfg_we, .cfg_idx, .cfg_data, .job_valid, .job_ready, .job
  );

  mcic_engine #(.STACK_DEPTH(STACK_DEPTH)) u_engine (
    .clk, .rst, .job_valid, .job_ready, .job, .out_valid, .out_ready, .out_data
  );

endmodule

// ----- hw/rtl/mcic_checker.sv -----
module mcic_checker (
  input logic                clk,
  input logic                rst,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input mcic_pkg::out_beat_t out_data
);

  // hold a stalled result beat
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // unreachable chains report zero cost
  a_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.chain_ok |-> out_data.chain_cost == '0)
    else $error("cost without chain");

  // no full cover reports zero best
  a_best: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.best_ok |-> out_data.best_total == '0)
    else $error("best without cover");

  // no result right out of reset
  a_rst: assert property (@(posedge clk) !rst && $past(rst) |-> !out_valid)
    else $error("result after reset");

  // empty queue takes beats right out of reset
  a_rdy: assert property (@(posedge clk) !rst && $past(rst) |-> in_ready)
    else $error("input blocked after reset");

endmodule

bind min_cost_interval_cover mcic_checker u_chk (
  .clk, .rst, .in_ready, .out_valid, .out_ready, .out_data
);
